// ===== hw/rtl/a2p_pkg.sv =====
package a2p_pkg;

   // Field widths and output scaling
   localparam int COORD_WIDTH     = 16;
   localparam int ANGLE_FRAC_BITS = 7;
   localparam int OUT_WIDTH       = 16;

   // Ratio format: signed fraction with R_FRAC fractional bits, +1.0 held exactly
   localparam int R_FRAC     = 15;
   localparam int QUO_W      = R_FRAC + 1;
   localparam int CELL_COUNT = QUO_W;
   localparam int R_W        = R_FRAC + 2;

   // Magnitudes of numerator and denominator reach 2^COORD_WIDTH
   localparam int MAG_W = COORD_WIDTH + 1;
   localparam int EXT_W = COORD_WIDTH + 2;

   // Polynomial coefficients in degrees, CUBE_FRAC fractional bits
   localparam int CUBE_FRAC = 20;
   localparam int CUBE_W    = 24;
   localparam int LIN_CW    = 26;
   localparam logic [CUBE_W-1:0] COEF_CUBE = 24'd11793504;
   localparam logic [LIN_CW-1:0] COEF_LIN  = 26'd58979534;

   localparam int SQ_W    = 2 * R_FRAC + 1;
   localparam int CPROD_W = CUBE_W + SQ_W;
   localparam int INNER_W = CUBE_W;
   localparam int LIN_W   = LIN_CW + 1;
   localparam int PROD_W  = LIN_W + R_W;

   // Final sum: base angle plus correction, SUM_FRAC fractional bits
   localparam int SUM_FRAC = CUBE_FRAC + R_FRAC;
   localparam int BASE_W   = 8;
   localparam int TOTAL_W  = SUM_FRAC + BASE_W + 3;
   localparam int SHIFT    = SUM_FRAC - ANGLE_FRAC_BITS;
   localparam logic [BASE_W-1:0] BASE_LO = 8'd45;
   localparam logic [BASE_W-1:0] BASE_HI = 8'd135;

   // Item traveling down the divider chain
   typedef struct packed {
      logic             valid;
      logic [MAG_W-1:0] den;
      logic [MAG_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic             num_neg;
      logic             base_hi;
      logic             y_neg;
      logic             zero;
   } a2p_tok_type;

   // Item leaving the polynomial stages
   typedef struct packed {
      logic                     valid;
      logic                     base_hi;
      logic                     y_neg;
      logic signed [PROD_W-1:0] prod;
   } a2p_prod_type;

endpackage

// ===== hw/rtl/atan2_poly_approx_degrees.sv =====
// Four-quadrant angle of (x, y) in 1/128 degree, by the octant-ratio cubic
// approximation of atan2; x = y = 0 gives +90 degrees. The block takes one
// item per clock unless stalled and passes it through one input
// stage, a chain of 16 divider cells that each resolve one quotient bit of
// the ratio, three multiply stages and the output register. While a result
// waits under rsp_stall the whole pipeline holds and req_stall is raised;
// otherwise a new item may enter in every cycle.
module atan2_poly_approx_degrees
   import a2p_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_coord_x,
   input  logic signed [COORD_WIDTH-1:0] req_coord_y,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [OUT_WIDTH-1:0] rsp_angle_deg
);

   logic adv;

   // Front end: octant ratio operands
   logic signed [EXT_W-1:0] x_ext;
   logic signed [EXT_W-1:0] y_ext;
   logic signed [EXT_W-1:0] ay;
   logic signed [EXT_W-1:0] num;
   logic signed [EXT_W-1:0] den;
   logic signed [EXT_W-1:0] mag;
   a2p_tok_type             front_in;
   a2p_tok_type             front_ff;

   a2p_tok_type  tok [0:CELL_COUNT];
   a2p_prod_type prod;

   // Back end: base plus correction, rounded
   logic signed [TOTAL_W-1:0]   total;
   logic signed [TOTAL_W-1:0]   shifted;
   logic [OUT_WIDTH-1:0]        ang_lo;
   logic [BASE_W-1:0]           base;
   logic                        rsp_valid_ff;
   logic signed [OUT_WIDTH-1:0] rsp_angle_ff;
   logic signed [OUT_WIDTH-1:0] angle_in;

   // Hold everything while the output item is stalled
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   always_comb begin
      x_ext = EXT_W'(req_coord_x);
      y_ext = EXT_W'(req_coord_y);
      ay    = y_ext[EXT_W-1] ? -y_ext : y_ext;
      if (x_ext[EXT_W-1]) begin
         num = x_ext + ay;
         den = ay - x_ext;
      end else begin
         num = x_ext - ay;
         den = x_ext + ay;
      end
      mag = num[EXT_W-1] ? -num : num;
      front_in.valid   = req_valid;
      front_in.den     = den[MAG_W-1:0];
      front_in.rem     = mag[MAG_W-1:0];
      front_in.quo     = '0;
      front_in.num_neg = num[EXT_W-1];
      front_in.base_hi = x_ext[EXT_W-1];
      front_in.y_neg   = y_ext[EXT_W-1];
      front_in.zero    = (den == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
      end else if (adv) begin
         front_ff <= front_in;
      end
   end

   assign tok[0] = front_ff;

   // Divider chain, one quotient bit per cell
   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      a2p_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1])
      );
   end

   a2p_poly u_poly (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .tok_in   (tok[CELL_COUNT]),
      .prod_out (prod)
   );

   // Add base angle, round to nearest, negate for lower half plane
   always_comb begin
      base    = prod.base_hi ? BASE_HI : BASE_LO;
      total   = $signed({3'b000, base, {SUM_FRAC{1'b0}}}) + TOTAL_W'(prod.prod)
                + $signed(TOTAL_W'(1) <<< (SHIFT - 1));
      shifted = total >>> SHIFT;
      ang_lo  = shifted[OUT_WIDTH-1:0];
      angle_in = prod.y_neg ? -$signed(ang_lo) : $signed(ang_lo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= prod.valid;
         rsp_angle_ff <= angle_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_angle_deg = rsp_angle_ff;

   // An accepted item lands in the input stage
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> front_ff.valid)
      else $error("accepted item lost at input stage");

   // A stalled output freezes the input side
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("input taken while output stalled");

   // No result leaves the cycle after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

endmodule

// ===== hw/rtl/a2p_div_cell.sv =====
module a2p_div_cell
   import a2p_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  a2p_tok_type tok_in,
   output a2p_tok_type tok_out
);

   a2p_tok_type      tok_ff;
   a2p_tok_type      tok_in_c;
   logic             ge;
   logic [MAG_W-1:0] diff;
   logic [MAG_W-1:0] rem_n;

   // Compare, subtract, shift: one quotient bit per cell
   always_comb begin
      ge    = (tok_in.rem >= tok_in.den);
      diff  = tok_in.rem - tok_in.den;
      rem_n = ge ? diff : tok_in.rem;
      tok_in_c     = tok_in;
      tok_in_c.rem = {rem_n[MAG_W-2:0], 1'b0};
      tok_in_c.quo = {tok_in.quo[QUO_W-2:0], ge};
   end

   // Advance the item with the rest of the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (adv) begin
         tok_ff <= tok_in_c;
      end
   end

   assign tok_out = tok_ff;

   // Partial remainder stays below twice the divisor
   assert property (@(posedge clock) disable iff (reset)
      (tok_ff.valid && !tok_ff.zero) |-> ({1'b0, tok_ff.rem} < {tok_ff.den, 1'b0}))
      else $error("divider cell remainder out of range");

   // Zero divisor only comes with a zero remainder
   assert property (@(posedge clock) disable iff (reset)
      (tok_ff.valid && tok_ff.zero) |-> (tok_ff.rem == '0 && tok_ff.den == '0))
      else $error("zero case carries nonzero data");

   // A held stage keeps its valid bit
   assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(tok_ff.valid))
      else $error("divider cell moved while held");

endmodule

// ===== hw/rtl/a2p_poly.sv =====
module a2p_poly
   import a2p_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         adv,
   input  a2p_tok_type  tok_in,
   output a2p_prod_type prod_out
);

   // Stage 0: ratio magnitude and its square
   logic              s0_valid_ff;
   logic              s0_r_neg_ff;
   logic [QUO_W-1:0]  s0_r_mag_ff;
   logic [SQ_W-1:0]   s0_sq_ff;
   logic              s0_base_hi_ff;
   logic              s0_y_neg_ff;
   logic [QUO_W-1:0]  r_mag_in;
   logic [2*QUO_W-1:0] sq_full;

   // Stage 1: cubic term less linear coefficient
   logic                    s1_valid_ff;
   logic signed [LIN_W-1:0] s1_lin_ff;
   logic signed [R_W-1:0]   s1_r_ff;
   logic                    s1_base_hi_ff;
   logic                    s1_y_neg_ff;
   logic [CPROD_W-1:0]      cube;
   logic [INNER_W-1:0]      inner;
   logic signed [LIN_W-1:0] lin_in;
   logic signed [R_W-1:0]   r_in;

   // Stage 2: times the ratio
   a2p_prod_type prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   // Both coordinates zero: ratio is -1.0
   always_comb begin
      r_mag_in = tok_in.zero ? QUO_W'(1 << R_FRAC) : tok_in.quo;
      sq_full  = r_mag_in * r_mag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff   <= tok_in.valid;
         s0_r_neg_ff   <= tok_in.zero | tok_in.num_neg;
         s0_r_mag_ff   <= r_mag_in;
         s0_sq_ff      <= sq_full[SQ_W-1:0];
         s0_base_hi_ff <= tok_in.base_hi;
         s0_y_neg_ff   <= tok_in.y_neg;
      end
   end

   // Truncate the cubic term, then subtract the linear coefficient
   always_comb begin
      cube   = CPROD_W'(COEF_CUBE) * CPROD_W'(s0_sq_ff);
      inner  = cube[2*R_FRAC +: INNER_W];
      lin_in = $signed(LIN_W'(inner)) - $signed(LIN_W'(COEF_LIN));
      r_in   = s0_r_neg_ff ? -$signed(R_W'(s0_r_mag_ff)) : $signed(R_W'(s0_r_mag_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff   <= s0_valid_ff;
         s1_lin_ff     <= lin_in;
         s1_r_ff       <= r_in;
         s1_base_hi_ff <= s0_base_hi_ff;
         s1_y_neg_ff   <= s0_y_neg_ff;
      end
   end

   assign prod_in = PROD_W'(s1_lin_ff) * PROD_W'(s1_r_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff.valid <= 1'b0;
      end else if (adv) begin
         prod_ff.valid   <= s1_valid_ff;
         prod_ff.base_hi <= s1_base_hi_ff;
         prod_ff.y_neg   <= s1_y_neg_ff;
         prod_ff.prod    <= prod_in;
      end
   end

   assign prod_out = prod_ff;

endmodule
